@@ design/mhpq_pkg.sv @@
// Shared constants, codes and link types for the max-heap priority queue.
package mhpq_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic                      cmp_en;
    logic                      ins_en;
    logic                      del_en;
    logic signed [VALUE_W-1:0] key;
  } ctl_t;

  // What a cell shows its neighbors and the controller
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic                      lt;   // slot empty or held value below key
    logic                      le;   // held value at or below key
    logic                      hit;  // held value equals key
  } cell_t;

endpackage

@@ design/mhpq_cell.sv @@
// One slot of the sorted chain: holds an entry, shifts right on insert, left on delete.
module mhpq_cell (
  input  logic           clk,
  input  logic           rst,
  input  mhpq_pkg::ctl_t  ctl,
  input  mhpq_pkg::cell_t left,
  input  mhpq_pkg::cell_t right,
  output mhpq_pkg::cell_t self
);

  logic                               valid;
  logic signed [mhpq_pkg::VALUE_W-1:0] value;
  logic                               lt;
  logic                               le;
  logic                               hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins_en && lt) begin
      // take the left neighbor's entry, or the new key at the insertion point
      valid <= left.lt ? left.valid : 1'b1;
    end else if (ctl.del_en && le) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt  <= !valid || (value < ctl.key);
      le  <= valid && (value <= ctl.key);
      hit <= valid && (value == ctl.key);
    end
    if (ctl.ins_en && lt) begin
      value <= left.lt ? left.value : ctl.key;
    end else if (ctl.del_en && le) begin
      value <= right.value;
    end
  end

  assign self = '{valid: valid, value: value, lt: lt, le: le, hit: hit};

endmodule

@@ design/max_heap_priority_queue_core.sv @@
// Bounded max-priority queue built as a sorted chain of entry cells.
// Steps per item: accept in S_IDLE, compare in S_CMP, shift in S_APPLY, report in S_DONE,
// with all cells stepping together; done strobes in S_DONE. A new item is accepted
// only back in S_IDLE, after the previous one has reported.
// Reset (rst, synchronous): queue empties, count is zero, busy drops.
// Results cannot be stalled: done is high for exactly one cycle per item.
module max_heap_priority_queue_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               action,
  input  logic signed [mhpq_pkg::VALUE_W-1:0] value,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [mhpq_pkg::COUNT_W-1:0]        count,
  output logic                               top_valid,
  output logic signed [mhpq_pkg::VALUE_W-1:0] top_value
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_DONE
  } state_t;

  state_t                             state;
  logic                               op_del;
  logic signed [mhpq_pkg::VALUE_W-1:0] key;
  mhpq_pkg::status_t                  st;
  logic [mhpq_pkg::COUNT_W-1:0]        cnt;

  mhpq_pkg::ctl_t  ctl;
  mhpq_pkg::cell_t cells [mhpq_pkg::CAPACITY];
  logic [mhpq_pkg::CAPACITY-1:0] hits;
  logic found;
  logic full;
  logic empty;

  assign full  = (cnt == mhpq_pkg::COUNT_W'(mhpq_pkg::CAPACITY));
  assign empty = (cnt == '0);
  assign found = |hits;

  always_comb begin
    ctl.cmp_en = (state == S_CMP);
    ctl.ins_en = (state == S_APPLY) && !op_del && !full;
    ctl.del_en = (state == S_APPLY) && op_del && found;
    ctl.key    = key;
  end

  genvar i;
  generate
    for (i = 0; i < mhpq_pkg::CAPACITY; i++) begin : g_cell
      mhpq_pkg::cell_t left_n;
      mhpq_pkg::cell_t right_n;
      if (i == 0) begin : g_first
        assign left_n = '0;
      end else begin : g_mid_l
        assign left_n = cells[i-1];
      end
      if (i == mhpq_pkg::CAPACITY - 1) begin : g_last
        assign right_n = '0;
      end else begin : g_mid_r
        assign right_n = cells[i+1];
      end
      mhpq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl),
        .left  (left_n),
        .right (right_n),
        .self  (cells[i])
      );
      assign hits[i] = cells[i].hit;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      st    <= mhpq_pkg::ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          state <= S_DONE;
          if (!op_del) begin
            if (full) begin
              st <= mhpq_pkg::ST_FULL;
            end else begin
              st  <= mhpq_pkg::ST_OK;
              cnt <= cnt + 1'b1;
            end
          end else if (empty) begin
            st <= mhpq_pkg::ST_EMPTY;
          end else if (!found) begin
            st <= mhpq_pkg::ST_NOTFOUND;
          end else begin
            st  <= mhpq_pkg::ST_OK;
            cnt <= cnt - 1'b1;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // capture the item on accept
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_del <= (action == mhpq_pkg::ACT_DELETE);
      key    <= value;
    end
  end

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign status    = st;
  assign count     = cnt;
  assign top_valid = cells[0].valid;
  assign top_value = cells[0].valid ? cells[0].value : '0;

`ifndef ASSERT_OFF
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done outside a busy interval");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= mhpq_pkg::COUNT_W'(mhpq_pkg::CAPACITY))
    else $error("count above capacity");

  a_top_count: assert property (@(posedge clk) disable iff (rst)
    top_valid == (cnt != '0))
    else $error("head cell disagrees with count");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not start work");
`endif

endmodule

@@ tb/sv/tb_max_heap_priority_queue_core.sv @@
// Self-checking testbench for the max-heap priority queue core: heap model, random ops, gaps.
`timescale 1ns / 1ps

module tb_max_heap_priority_queue_core;

  localparam int RANDOM_OPS  = 1100;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_MAX  = 10;
  localparam int POOL_SIZE   = 6;

  typedef struct {
    mhpq_pkg::action_t                   act;
    logic signed [mhpq_pkg::VALUE_W-1:0] val;
    int unsigned                         gap;
    bit                                  drain;
  } queue_op_t;

  typedef struct {
    mhpq_pkg::status_t                   status;
    logic [mhpq_pkg::COUNT_W-1:0]        count;
    logic                                top_valid;
    logic signed [mhpq_pkg::VALUE_W-1:0] top_value;
  } queue_report_t;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  logic                                action = mhpq_pkg::ACT_INSERT;
  logic signed [mhpq_pkg::VALUE_W-1:0] value = '0;
  logic                                done;
  logic [1:0]                          status;
  logic [mhpq_pkg::COUNT_W-1:0]        count;
  logic                                top_valid;
  logic signed [mhpq_pkg::VALUE_W-1:0] top_value;

  queue_op_t     op_q[$];
  queue_report_t report_q[$];
  queue_op_t     cur_op;

  logic signed [mhpq_pkg::VALUE_W-1:0] heap_mem [mhpq_pkg::CAPACITY];
  int heap_n = 0;

  int total_ops    = 0;
  int accepted_cnt = 0;
  int mismatch_cnt = 0;
  int idle_cnt     = 0;
  int cycle_cnt    = 0;

  max_heap_priority_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .value     (value),
    .done      (done),
    .status    (status),
    .count     (count),
    .top_valid (top_valid),
    .top_value (top_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void heap_sift_down(int node);
    int big;
    int lc;
    int rc;
    bit settled;
    logic signed [mhpq_pkg::VALUE_W-1:0] tmp;
    settled = 1'b0;
    while (!settled) begin
      big = node;
      lc  = 2 * node + 1;
      rc  = 2 * node + 2;
      if (lc < heap_n && heap_mem[lc] > heap_mem[big]) big = lc;
      if (rc < heap_n && heap_mem[rc] > heap_mem[big]) big = rc;
      if (big == node) begin
        settled = 1'b1;
      end else begin
        tmp            = heap_mem[node];
        heap_mem[node] = heap_mem[big];
        heap_mem[big]  = tmp;
        node           = big;
      end
    end
  endfunction

  function automatic void heap_rebuild();
    for (int k = heap_n / 2 - 1; k >= 0; k--) heap_sift_down(k);
  endfunction

  function automatic queue_report_t heap_apply_op(mhpq_pkg::action_t act,
                                                 logic signed [mhpq_pkg::VALUE_W-1:0] val);
    queue_report_t rep;
    int idx;
    logic signed [mhpq_pkg::VALUE_W-1:0] tmp;
    rep.status = mhpq_pkg::ST_OK;
    if (act == mhpq_pkg::ACT_INSERT) begin
      if (heap_n >= mhpq_pkg::CAPACITY) begin
        rep.status = mhpq_pkg::ST_FULL;
      end else begin
        heap_mem[heap_n] = val;
        heap_n++;
        heap_rebuild();
      end
    end else if (heap_n == 0) begin
      rep.status = mhpq_pkg::ST_EMPTY;
    end else begin
      idx = 0;
      while (idx < heap_n && heap_mem[idx] != val) idx++;
      if (idx == heap_n) begin
        rep.status = mhpq_pkg::ST_NOTFOUND;
      end else begin
        // swap the first match with the last entry, then shrink
        tmp                  = heap_mem[idx];
        heap_mem[idx]        = heap_mem[heap_n - 1];
        heap_mem[heap_n - 1] = tmp;
        heap_n--;
        heap_rebuild();
      end
    end
    rep.count     = mhpq_pkg::COUNT_W'(heap_n);
    rep.top_valid = (heap_n > 0);
    rep.top_value = (heap_n > 0) ? heap_mem[0] : '0;
    return rep;
  endfunction

  task automatic push_op(mhpq_pkg::action_t act, logic signed [mhpq_pkg::VALUE_W-1:0] val,
                         int unsigned gap, bit drain);
    queue_op_t op;
    op.act   = act;
    op.val   = val;
    op.gap   = gap;
    op.drain = drain;
    op_q.push_back(op);
  endtask

  task automatic report_mismatch(string fld, logic [mhpq_pkg::VALUE_W-1:0] want,
                                 logic [mhpq_pkg::VALUE_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, fld, want, got);
  endtask

  // Driver: hold start until accepted, then wait the next item's gap
  always @(posedge clk) begin
    bit launch;
    launch = start;
    if (rst) begin
      launch   = 1'b0;
      idle_cnt = 0;
    end else begin
      if (start && !busy) begin
        report_q.push_back(heap_apply_op(cur_op.act, cur_op.val));
        accepted_cnt++;
        launch = 1'b0;
      end
      if (!launch && op_q.size() != 0) begin
        if (op_q[0].drain && report_q.size() != 0) begin
          idle_cnt = 0;
        end else if (idle_cnt < op_q[0].gap) begin
          idle_cnt++;
        end else begin
          cur_op = op_q.pop_front();
          action <= cur_op.act;
          value  <= cur_op.val;
          launch   = 1'b1;
          idle_cnt = 0;
        end
      end
    end
    start <= launch;
  end

  // Monitor: every strobe must match the oldest pending report
  always @(posedge clk) begin
    queue_report_t want;
    if (!rst && done) begin
      if (report_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("%0t: result with no item pending: status %0d count %0d", $realtime,
                   status, count);
      end else begin
        want = report_q.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(status));
        if (count !== want.count)
          report_mismatch("count", 32'(want.count), 32'(count));
        if (top_valid !== want.top_valid)
          report_mismatch("top_valid", 32'(want.top_valid), 32'(top_valid));
        if (top_value !== want.top_value)
          report_mismatch("top_value", want.top_value, top_value);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic signed [mhpq_pkg::VALUE_W-1:0] pool [POOL_SIZE];
    logic signed [mhpq_pkg::VALUE_W-1:0] val;
    mhpq_pkg::action_t act;
    int unsigned gap;
    int gen;
    int blk_len;
    int ins_pct;
    int gap_mode;

    // directed: empty delete, extremes, duplicates, absent value, fill to full
    push_op(mhpq_pkg::ACT_DELETE, 0, 0, 1'b0);
    push_op(mhpq_pkg::ACT_INSERT, 32'sh7fffffff, $urandom_range(0, 18), 1'b0);
    push_op(mhpq_pkg::ACT_INSERT, 32'sh80000000, 0, 1'b0);
    push_op(mhpq_pkg::ACT_INSERT, 0, $urandom_range(0, 18), 1'b0);
    push_op(mhpq_pkg::ACT_INSERT, -1, 0, 1'b0);
    push_op(mhpq_pkg::ACT_INSERT, -1, 0, 1'b0);
    push_op(mhpq_pkg::ACT_DELETE, 5, $urandom_range(0, 18), 1'b0);
    push_op(mhpq_pkg::ACT_DELETE, -1, 0, 1'b0);
    push_op(mhpq_pkg::ACT_DELETE, 32'sh7fffffff, 0, 1'b0);
    push_op(mhpq_pkg::ACT_INSERT, 32'sh55555555, 0, 1'b0);
    push_op(mhpq_pkg::ACT_INSERT, 32'shaaaaaaaa, 0, 1'b0);
    for (int i = 0; i < 11; i++)
      push_op(mhpq_pkg::ACT_INSERT, $urandom(), $urandom_range(0, 3), 1'b0);
    push_op(mhpq_pkg::ACT_INSERT, 32'sh7fffffff, 0, 1'b0);
    push_op(mhpq_pkg::ACT_DELETE, 32'sh80000000, $urandom_range(0, 18), 1'b0);
    push_op(mhpq_pkg::ACT_DELETE, 32'sh55555555, 0, 1'b0);

    // random: blocks that lean toward filling, draining or neither, values from a small pool
    gen = 0;
    while (gen < RANDOM_OPS) begin
      blk_len  = $urandom_range(12, 40);
      gap_mode = $urandom_range(0, 2);
      case ($urandom_range(0, 3))
        0: ins_pct = 15;
        1: ins_pct = 50;
        2: ins_pct = 85;
        default: ins_pct = 97;
      endcase
      for (int k = 0; k < POOL_SIZE; k++) begin
        case ($urandom_range(0, 3))
          0: pool[k] = 32'sh7fffffff;
          1: pool[k] = 32'sh80000000;
          2: pool[k] = $signed($urandom_range(0, 7)) - 4;
          default: pool[k] = $urandom();
        endcase
      end
      for (int j = 0; j < blk_len; j++) begin
        val = ($urandom_range(0, 99) < 75) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : $urandom();
        act = ($urandom_range(0, 99) < ins_pct) ? mhpq_pkg::ACT_INSERT
                                                 : mhpq_pkg::ACT_DELETE;
        case (gap_mode)
          0: gap = 0;
          1: gap = $urandom_range(0, 18);
          default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        endcase
        push_op(act, val, gap, (gen == 0) || (j == 0 && $urandom_range(0, 4) == 0));
        gen++;
      end
    end
    total_ops = op_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cnt < total_ops || report_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && report_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
